// File: design/fcgm_pkg.sv
package fcgm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int NUM_CH      = 4;
  localparam int MUTE_BITS   = NUM_CH;
  localparam int CNT_W       = $clog2(NUM_CH + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = GAIN_BITS;

  localparam int PROD_W      = SAMPLE_BITS + GAIN_BITS;
  localparam int SUM_W       = PROD_W + $clog2(NUM_CH);
  localparam int QUO_W       = SUM_W - GAIN_FRAC;

  localparam int DIV_K       = QUO_W + 2;
  localparam int RECIP_W     = DIV_K - 1;
  localparam logic [RECIP_W-1:0] RECIP3 =
    RECIP_W'(((65'd1 << DIV_K) + 65'd2) / 65'd3);

  localparam logic [QUO_W-1:0] SAT_NEG_MAG = QUO_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [QUO_W-1:0] SAT_POS_MAG = SAT_NEG_MAG - QUO_W'(1);

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1) << GAIN_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_GAME   = 3'd0,
    REG_GAIN_CHAT   = 3'd1,
    REG_GAIN_MEDIA  = 3'd2,
    REG_GAIN_SYSTEM = 3'd3,
    REG_MUTE        = 3'd4
  } cfg_reg_t;

endpackage

// File: design/fcgm_avg.sv
module fcgm_avg (
  input  logic [fcgm_pkg::QUO_W-1:0] num,
  input  logic [fcgm_pkg::CNT_W-1:0] cnt,
  output logic [fcgm_pkg::QUO_W-1:0] quo
);

  logic [fcgm_pkg::QUO_W+fcgm_pkg::RECIP_W-1:0] recip_prod;
  logic [fcgm_pkg::QUO_W-1:0]                   third;

  assign recip_prod = (fcgm_pkg::QUO_W + fcgm_pkg::RECIP_W)'(num)
                    * (fcgm_pkg::QUO_W + fcgm_pkg::RECIP_W)'(fcgm_pkg::RECIP3);
  assign third = fcgm_pkg::QUO_W'(recip_prod >> fcgm_pkg::DIV_K);

  always_comb begin
    case (cnt)
      fcgm_pkg::CNT_W'(1): quo = num;
      fcgm_pkg::CNT_W'(2): quo = num >> 1;
      fcgm_pkg::CNT_W'(3): quo = third;
      fcgm_pkg::CNT_W'(4): quo = num >> 2;
      default:             quo = '0;
    endcase
  end

endmodule

// File: design/four_channel_gain_mixer.sv
// Pipeline: five register stages; an accepted item passes v1_r, v2_r, v3_r, v4_r and out_valid_r in order.
// Throughput: one item per cycle while out_stall is low; under out_stall full stages hold and empty ones fill.
// Stages: gain multiply, channel sum, magnitude, divide by active count, saturate.
// Reset: all valid bits clear, every gain loads unity (4096), no channel muted.
module four_channel_gain_mixer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fcgm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcgm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fcgm_pkg::SAMPLE_BITS-1:0] in_game_sample,
  input  logic signed [fcgm_pkg::SAMPLE_BITS-1:0] in_chat_sample,
  input  logic signed [fcgm_pkg::SAMPLE_BITS-1:0] in_media_sample,
  input  logic signed [fcgm_pkg::SAMPLE_BITS-1:0] in_system_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fcgm_pkg::SAMPLE_BITS-1:0] out_left_sample,
  output logic signed [fcgm_pkg::SAMPLE_BITS-1:0] out_right_sample
);

  logic [fcgm_pkg::GAIN_BITS-1:0] gain_r [fcgm_pkg::NUM_CH];
  logic [fcgm_pkg::MUTE_BITS-1:0] mute_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5;

  logic signed [fcgm_pkg::SAMPLE_BITS-1:0] samp [fcgm_pkg::NUM_CH];
  logic signed [fcgm_pkg::PROD_W-1:0]      mul_full [fcgm_pkg::NUM_CH];
  logic signed [fcgm_pkg::PROD_W-1:0]      prod_r [fcgm_pkg::NUM_CH];
  logic [fcgm_pkg::CNT_W-1:0]              cnt1_r, cnt2_r, cnt3_r, cnt4_r;

  logic signed [fcgm_pkg::SUM_W-1:0]       sum_nxt, sum_r;
  logic [fcgm_pkg::SUM_W-1:0]              mag;
  logic [fcgm_pkg::QUO_W-1:0]              x3_r;
  logic                                    neg3_r, neg4_r;
  logic [fcgm_pkg::QUO_W-1:0]              quo, q4_r;
  logic [fcgm_pkg::QUO_W-1:0]              q_clip;
  logic [fcgm_pkg::SAMPLE_BITS-1:0]        out_nxt, out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < fcgm_pkg::NUM_CH; c++) begin
        gain_r[c] <= fcgm_pkg::GAIN_UNITY;
      end
      mute_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcgm_pkg::REG_GAIN_GAME:   gain_r[0] <= cfg_wdata;
        fcgm_pkg::REG_GAIN_CHAT:   gain_r[1] <= cfg_wdata;
        fcgm_pkg::REG_GAIN_MEDIA:  gain_r[2] <= cfg_wdata;
        fcgm_pkg::REG_GAIN_SYSTEM: gain_r[3] <= cfg_wdata;
        fcgm_pkg::REG_MUTE:        mute_r <= cfg_wdata[fcgm_pkg::MUTE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance chain
  assign adv5     = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) out_valid_r <= v4_r;
    end
  end

  // stage 1: gain multiply
  assign samp[0] = in_game_sample;
  assign samp[1] = in_chat_sample;
  assign samp[2] = in_media_sample;
  assign samp[3] = in_system_sample;

  always_comb begin
    for (int c = 0; c < fcgm_pkg::NUM_CH; c++) begin
      mul_full[c] = samp[c] * $signed({1'b0, gain_r[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int c = 0; c < fcgm_pkg::NUM_CH; c++) begin
        prod_r[c] <= mute_r[c] ? '0 : mul_full[c];
      end
      cnt1_r <= fcgm_pkg::CNT_W'($countones(~mute_r));
    end
  end

  // stage 2: sum
  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < fcgm_pkg::NUM_CH; c++) begin
      sum_nxt = sum_nxt + fcgm_pkg::SUM_W'(prod_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sum_r  <= sum_nxt;
      cnt2_r <= cnt1_r;
    end
  end

  // stage 3: magnitude, drop gain fraction
  assign mag = sum_r[fcgm_pkg::SUM_W-1] ? fcgm_pkg::SUM_W'(-sum_r) : fcgm_pkg::SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (adv3) begin
      x3_r   <= mag[fcgm_pkg::SUM_W-1:fcgm_pkg::GAIN_FRAC];
      neg3_r <= sum_r[fcgm_pkg::SUM_W-1];
      cnt3_r <= cnt2_r;
    end
  end

  // stage 4: average
  fcgm_avg u_avg (
    .num (x3_r),
    .cnt (cnt3_r),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (adv4) begin
      q4_r   <= quo;
      neg4_r <= neg3_r;
      cnt4_r <= cnt3_r;
    end
  end

  // stage 5: saturate
  always_comb begin
    if (neg4_r) begin
      q_clip  = (q4_r > fcgm_pkg::SAT_NEG_MAG) ? fcgm_pkg::SAT_NEG_MAG : q4_r;
      out_nxt = fcgm_pkg::SAMPLE_BITS'(-q_clip);
    end else begin
      q_clip  = (q4_r > fcgm_pkg::SAT_POS_MAG) ? fcgm_pkg::SAT_POS_MAG : q4_r;
      out_nxt = q_clip[fcgm_pkg::SAMPLE_BITS-1:0];
    end
    if (cnt4_r == '0) begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_r;
  assign out_right_sample = out_r;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fcgm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t frame_t [NUM_CH];

  typedef struct packed {
    sample_t left;
    sample_t right;
  } mix_result_t;

  localparam longint  FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);
  localparam sample_t SAMPLE_MAX = sample_t'(FULL_SCALE - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(FULL_SCALE);
  localparam int      SETTLE_CYCLES = 8;

  class mix_scoreboard;
    logic [GAIN_BITS-1:0] gain [NUM_CH];
    logic [MUTE_BITS-1:0] mute;
    mix_result_t          mixed_q [$];
    int                   errors;

    function new();
      for (int c = 0; c < NUM_CH; c++) gain[c] = GAIN_UNITY;
      mute   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < NUM_CH) begin
        gain[idx] = data[GAIN_BITS-1:0];
      end else if (idx == REG_MUTE) begin
        mute = data[MUTE_BITS-1:0];
      end
    endfunction

    function mix_result_t mix_frame(frame_t f);
      longint      acc;
      longint      mag;
      longint      quo;
      longint      smp;
      int          active;
      mix_result_t r;
      acc    = 0;
      active = 0;
      for (int c = 0; c < NUM_CH; c++) begin
        if (!mute[c]) begin
          smp = f[c];
          acc += smp * longint'(gain[c]);
          active++;
        end
      end
      r.left = '0;
      if (active != 0) begin
        mag = (acc < 0) ? -acc : acc;
        quo = mag / (longint'(active) << GAIN_FRAC);
        if (acc < 0) begin
          if (quo > FULL_SCALE) quo = FULL_SCALE;
          r.left = sample_t'(-quo);
        end else begin
          if (quo > FULL_SCALE - 1) quo = FULL_SCALE - 1;
          r.left = sample_t'(quo);
        end
      end
      r.right = r.left;
      return r;
    endfunction

    function void note_frame(frame_t f);
      mixed_q.push_back(mix_frame(f));
    endfunction

    function void check_output(sample_t left, sample_t right);
      mix_result_t want;
      if (mixed_q.size() == 0) begin
        $error("unexpected item: left_sample %0d right_sample %0d", left, right);
        errors++;
        return;
      end
      want = mixed_q.pop_front();
      if (left !== want.left) begin
        $error("left_sample: expected %0d, got %0d", want.left, left);
        errors++;
      end
      if (right !== want.right) begin
        $error("right_sample: expected %0d, got %0d", want.right, right);
        errors++;
      end
    endfunction

    function int pending();
      return mixed_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  sample_t                in_game_sample;
  sample_t                in_chat_sample;
  sample_t                in_media_sample;
  sample_t                in_system_sample;
  logic                   out_valid;
  logic                   out_stall;
  sample_t                out_left_sample;
  sample_t                out_right_sample;

  int            send_idle_pct = 0;
  int            stall_pct = 0;
  mix_scoreboard sb = new();

  four_channel_gain_mixer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_game_sample   (in_game_sample),
    .in_chat_sample   (in_chat_sample),
    .in_media_sample  (in_media_sample),
    .in_system_sample (in_system_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_output(out_left_sample, out_right_sample);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_game_sample   <= f[0];
    in_chat_sample   <= f[1];
    in_media_sample  <= f[2];
    in_system_sample <= f[3];
    do @(negedge clk); while (in_stall);
    sb.note_frame(f);
    @(posedge clk);
  endtask

  task automatic send4(sample_t g, sample_t c, sample_t m, sample_t s);
    frame_t f;
    f = '{g, c, m, s};
    send_item(f);
  endtask

  // hold off until every item has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_mix(logic [GAIN_BITS-1:0] g0, logic [GAIN_BITS-1:0] g1,
                         logic [GAIN_BITS-1:0] g2, logic [GAIN_BITS-1:0] g3,
                         logic [MUTE_BITS-1:0] mask);
    settle();
    cfg_write(REG_GAIN_GAME, g0);
    cfg_write(REG_GAIN_CHAT, g1);
    cfg_write(REG_GAIN_MEDIA, g2);
    cfg_write(REG_GAIN_SYSTEM, g3);
    cfg_write(REG_MUTE, CFG_DATA_W'(mask));
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return SAMPLE_MAX;
      2:       return SAMPLE_MIN;
      3:       return sample_t'($urandom_range(512) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] rand_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return GAIN_UNITY;
      2:       return '1;
      3:       return GAIN_BITS'($urandom_range(2 * GAIN_UNITY));
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  initial begin
    frame_t f;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_game_sample   <= '0;
    in_chat_sample   <= '0;
    in_media_sample  <= '0;
    in_system_sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send4(0, 0, 0, 0);
    send4(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send4(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    send4(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    send4(-1, -1, -1, 0);
    send4(1, 2, 3, SAMPLE_MIN);

    // unused indices and excess mute bits must leave the mix untouched
    settle();
    for (int i = int'(REG_MUTE) + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), '1);
    end
    cfg_write(REG_MUTE, CFG_DATA_W'(16'hFFF0));
    cfg_we <= 1'b0;
    send4(100, 200, 300, 400);

    set_mix('1, '1, '1, '1, 4'b0000);
    send4(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send4(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    send4(SAMPLE_MAX, SAMPLE_MIN, 0, 0);

    set_mix(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, 4'b1111);
    send4(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send4(SAMPLE_MIN, 123, -456, SAMPLE_MIN);

    set_mix('0, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, 4'b1000);
    send4(100, -7, -7, 999);
    send4(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0);

    set_mix(GAIN_UNITY, '0, '0, '0, 4'b1110);
    send4(SAMPLE_MIN, 5, 6, 7);
    send4(12345, SAMPLE_MAX, SAMPLE_MIN, 0);

    set_mix('1, 1, 16'd8191, 16'd4097, 4'b0101);
    send4(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    send4(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
    send4(-3, 9, 0, -11);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        set_mix(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                MUTE_BITS'($urandom_range(15)));
        for (int n = 0; n < 62; n++) begin
          if (seg == 2 && n == 31) settle();
          for (int c = 0; c < NUM_CH; c++) f[c] = rand_sample();
          send_item(f);
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fcgm_pkg.sv
design/fcgm_avg.sv
design/four_channel_gain_mixer.sv
bench/testbench.sv
